/* hw/rtl/lr_injection_observer_core_assert.svh */
// Assertion macros shared by the observer RTL.
`ifndef LR_INJECTION_OBSERVER_CORE_ASSERT_SVH
`define LR_INJECTION_OBSERVER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LIO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("observer assertion failed");

// Next-cycle implication, checked out of reset.
`define LIO_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("observer assertion failed");

`endif

/* hw/rtl/lio_pkg.sv */
// Shared types and constants of the resistance and inductance observer.
package lio_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int REQ_DATA_W      = 128;
   localparam int RSP_DATA_W      = 96;
   localparam int DIV_HI_W        = 64;
   localparam int DIV_Q_W         = 32;

   // 6.28 in Q16
   localparam logic [18:0] K628      = 19'd411566;
   localparam logic [17:0] PWM_RESET = 18'd20000;
   localparam logic [19:0] INJ_RESET = 20'd65536;

   typedef enum logic {
      CSR_PWM = 1'b0,
      CSR_INJ = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_DSTART,
      ST_DWAIT,
      ST_COMMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_R,
      OP_L,
      OP_AD,
      OP_AQ
   } op_type;

   typedef struct packed {
      logic   collect;
      logic   load;
      logic   prep1;
      logic   prep2;
      logic   prep3;
      logic   div_start;
      logic   div_capture;
      op_type div_op;
      logic   commit;
   } cmd_type;

   typedef struct packed {
      logic run_now;
      logic go_now;
      logic go_held;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/lio_div.sv */
// Restoring divider: 32 quotient bits of {num_hi,num_lo}/den with overflow flag.
module lio_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lio_pkg::DIV_HI_W-1:0]      num_hi,
   input  logic [lio_pkg::DIV_Q_W-1:0]       num_lo,
   input  logic [lio_pkg::DIV_HI_W-1:0]      den,
   output logic                              done,
   output logic [lio_pkg::DIV_Q_W-1:0]       quot,
   output logic                              ovf
);

   localparam int HW = lio_pkg::DIV_HI_W;
   localparam int QW = lio_pkg::DIV_Q_W;
   localparam int CW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [HW-1:0] r_ff, r_in;
   logic [QW-1:0] lo_ff, lo_in;
   logic [QW-1:0] q_ff, q_in;
   logic [HW-1:0] den_ff, den_in;
   logic          ovf_ff, ovf_in;

   logic [HW:0] rs;
   logic [HW:0] diff;
   logic        ge;

   always_comb begin
      rs   = {r_ff, lo_ff[QW-1]};
      diff = rs - {1'b0, den_ff};
      ge   = rs >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      ovf_in  = ovf_ff;

      if (start) begin
         den_in = den;
         r_in   = num_hi;
         lo_in  = num_lo;
         cnt_in = '0;
         q_in   = '0;
         ovf_in = 1'b0;
         if (den == '0) begin
            done_in = 1'b1;
         end else if (num_hi >= den) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         r_in   = ge ? diff[HW-1:0] : rs[HW-1:0];
         lo_in  = {lo_ff[QW-2:0], 1'b0};
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign ovf  = ovf_ff;

endmodule

/* hw/rtl/lio_datapath.sv */
// Observer datapath: accumulators, averages, estimate arithmetic and result register.
module lio_datapath #(
   parameter int COUNT_WIDTH = lio_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lio_pkg::cmd_type                  cmd,
   output lio_pkg::status_type               status,
   input  logic [lio_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [0:0]                        req_tuser,
   input  logic                              csr_valid,
   input  logic [0:0]                        csr_index,
   input  logic [19:0]                       csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [lio_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser
);

   localparam int HW = lio_pkg::DIV_HI_W;
   localparam int QW = lio_pkg::DIV_Q_W;

   // request fields
   logic [15:0] in_vd, in_vq;
   logic [31:0] in_e, in_id;
   logic [23:0] in_flux;
   logic        in_hfi;
   assign in_vd   = req_tdata[15:0];
   assign in_vq   = req_tdata[31:16];
   assign in_e    = req_tdata[63:32];
   assign in_flux = req_tdata[87:64];
   assign in_hfi  = req_tdata[88];
   assign in_id   = req_tdata[120:89];

   // configuration
   logic [17:0] pwm_ff;
   logic [19:0] inj_ff;

   // observer state
   logic                   phase_low_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [31:0]            vd_low_sum_ff, vq_low_sum_ff, vd_high_sum_ff, vq_high_sum_ff;
   logic [15:0]            vd_low_avg_ff, vq_low_avg_ff, vd_high_avg_ff, vq_high_avg_ff;
   logic [31:0]            prev_e_ff;
   logic [31:0]            held_r_ff, held_l_ff;

   // item held during a run
   logic [31:0] e_ff, id_ff;
   logic [23:0] flux_ff;
   logic        go_ff;

   // pipeline of the inductance numerator and denominator
   logic [56:0] p_ff;
   logic [30:0] ik_ff;
   logic        de_neg_ff;
   logic [31:0] mag_e_ff;
   logic [44:0] t2_ff;
   logic [62:0] den_ff;
   logic [45:0] n_mag_ff;
   logic        l_neg_ff;

   // result register
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic        rsp_upd_ff;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [15:0] v);
      logic [32:0] a;
      a = {s[31], s} + {{17{v[15]}}, v};
      if (a[32] != a[31]) begin
         sat_add = a[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sat_add = a[31:0];
      end
   endfunction

   // speed and injection condition on the incoming word
   logic [39:0] spd_lhs, spd_rhs;
   assign spd_lhs = {8'd0, mag32(in_e)} * 40'd200;
   assign spd_rhs = {6'd0, pwm_ff, 16'd0};

   // arithmetic on held values
   logic [32:0] de, mag_de;
   logic [16:0] dd, dq, mag_dd;
   logic [59:0] prod_hi;
   logic [34:0] prod_lo;
   logic [60:0] t2_sum;
   logic [46:0] dq_sh, st2, n_val;
   logic [31:0] avg_sum;
   logic [38:0] ik_prod;

   assign ik_prod = inj_ff * lio_pkg::K628;

   always_comb begin
      de      = {e_ff[31], e_ff} - {prev_e_ff[31], prev_e_ff};
      mag_de  = de[32] ? (~de + 33'd1) : de;
      dd      = {vd_high_avg_ff[15], vd_high_avg_ff} - {vd_low_avg_ff[15], vd_low_avg_ff};
      dq      = {vq_high_avg_ff[15], vq_high_avg_ff} - {vq_low_avg_ff[15], vq_low_avg_ff};
      mag_dd  = dd[16] ? (~dd + 17'd1) : dd;
      prod_hi = p_ff[56:16] * lio_pkg::K628;
      prod_lo = p_ff[15:0] * lio_pkg::K628;
      t2_sum  = {1'b0, prod_hi} + {42'd0, prod_lo[34:16]};
      dq_sh   = {{14{dq[16]}}, dq, 16'd0};
      st2     = de_neg_ff ? (47'd0 - {2'd0, t2_ff}) : {2'd0, t2_ff};
      n_val   = dq_sh - st2;
   end

   // divider operands
   logic [HW-1:0] div_hi, div_den;
   logic [QW-1:0] div_lo;
   logic          div_done, div_ovf;
   logic [QW-1:0] div_q;

   always_comb begin
      avg_sum = '0;
      div_hi  = '0;
      div_lo  = '0;
      div_den = '0;
      case (cmd.div_op)
         lio_pkg::OP_R: begin
            div_hi  = HW'(mag_dd[16:9]);
            div_lo  = {mag_dd[8:0], 23'd0};
            div_den = HW'(inj_ff);
         end
         lio_pkg::OP_L: begin
            div_hi  = HW'({n_mag_ff, 15'd0});
            div_den = HW'(den_ff);
         end
         lio_pkg::OP_AD: begin
            avg_sum = phase_low_ff ? vd_low_sum_ff : vd_high_sum_ff;
            div_lo  = mag32(avg_sum);
            div_den = HW'(count_ff);
         end
         lio_pkg::OP_AQ: begin
            avg_sum = phase_low_ff ? vq_low_sum_ff : vq_high_sum_ff;
            div_lo  = mag32(avg_sum);
            div_den = HW'(count_ff);
         end
         default: begin
            avg_sum = '0;
         end
      endcase
   end

   lio_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num_hi (div_hi),
      .num_lo (div_lo),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_q),
      .ovf    (div_ovf)
   );

   // saturated, signed quotient for the estimates
   logic        est_neg;
   logic [31:0] est_cap, est_mag, est_val, avg_val;
   always_comb begin
      est_neg = (cmd.div_op == lio_pkg::OP_R) ? dd[16] : l_neg_ff;
      est_cap = est_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      est_mag = (div_ovf || (div_q > est_cap)) ? est_cap : div_q;
      est_val = est_neg ? (32'd0 - est_mag) : est_mag;
      avg_val = avg_sum[31] ? (32'd0 - div_q) : div_q;
   end

   // injection step
   logic [32:0] id_step;
   logic [31:0] id_new;
   always_comb begin
      if (phase_low_ff) begin
         id_step = {id_ff[31], id_ff} + {13'd0, inj_ff};
      end else begin
         id_step = {id_ff[31], id_ff} - {13'd0, inj_ff};
      end
      if (id_step[32] != id_step[31]) begin
         id_new = id_step[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         id_new = id_step[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_ff         <= lio_pkg::PWM_RESET;
         inj_ff         <= lio_pkg::INJ_RESET;
         phase_low_ff   <= 1'b1;
         count_ff       <= '0;
         vd_low_sum_ff  <= '0;
         vq_low_sum_ff  <= '0;
         vd_high_sum_ff <= '0;
         vq_high_sum_ff <= '0;
         vd_low_avg_ff  <= '0;
         vq_low_avg_ff  <= '0;
         vd_high_avg_ff <= '0;
         vq_high_avg_ff <= '0;
         prev_e_ff      <= '0;
         held_r_ff      <= '0;
         held_l_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (lio_pkg::csr_index_type'(csr_index))
               lio_pkg::CSR_PWM: pwm_ff <= csr_data[17:0];
               lio_pkg::CSR_INJ: inj_ff <= csr_data;
               default:          pwm_ff <= pwm_ff;
            endcase
         end

         if (cmd.collect) begin
            if (count_ff != '1) begin
               count_ff <= count_ff + 1'b1;
            end
            if (status.go_now) begin
               if (phase_low_ff) begin
                  vd_low_sum_ff <= sat_add(vd_low_sum_ff, in_vd);
                  vq_low_sum_ff <= sat_add(vq_low_sum_ff, in_vq);
               end else begin
                  vd_high_sum_ff <= sat_add(vd_high_sum_ff, in_vd);
                  vq_high_sum_ff <= sat_add(vq_high_sum_ff, in_vq);
               end
            end
         end

         if (cmd.div_capture) begin
            case (cmd.div_op)
               lio_pkg::OP_R: held_r_ff <= est_val;
               lio_pkg::OP_L: held_l_ff <= est_val;
               lio_pkg::OP_AD: begin
                  if (phase_low_ff) vd_low_avg_ff <= avg_val[15:0];
                  else vd_high_avg_ff <= avg_val[15:0];
               end
               lio_pkg::OP_AQ: begin
                  if (phase_low_ff) vq_low_avg_ff <= avg_val[15:0];
                  else vq_high_avg_ff <= avg_val[15:0];
               end
               default: held_r_ff <= held_r_ff;
            endcase
         end

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (go_ff) begin
               phase_low_ff <= !phase_low_ff;
               prev_e_ff    <= e_ff;
               count_ff     <= '0;
               if (phase_low_ff) begin
                  vd_low_sum_ff <= '0;
                  vq_low_sum_ff <= '0;
               end else begin
                  vd_high_sum_ff <= '0;
                  vq_high_sum_ff <= '0;
               end
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.load) begin
         e_ff    <= in_e;
         id_ff   <= in_id;
         flux_ff <= in_flux;
         go_ff   <= status.go_now;
      end
      if (cmd.prep1) begin
         p_ff      <= mag_de * flux_ff;
         ik_ff     <= ik_prod[38:8];
         de_neg_ff <= de[32];
         mag_e_ff  <= mag32(e_ff);
      end
      if (cmd.prep2) begin
         t2_ff  <= t2_sum[60:16];
         den_ff <= ik_ff * mag_e_ff;
      end
      if (cmd.prep3) begin
         n_mag_ff <= n_val[46] ? 46'(47'd0 - n_val) : n_val[45:0];
         l_neg_ff <= n_val[46] != e_ff[31];
      end
      if (cmd.commit) begin
         rsp_upd_ff  <= go_ff;
         rsp_data_ff <= {go_ff ? id_new : id_ff, held_l_ff, held_r_ff};
      end
   end

   always_comb begin
      status.run_now  = req_tuser[0];
      status.go_now   = !in_hfi && (spd_lhs > spd_rhs);
      status.go_held  = go_ff;
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_upd_ff;

endmodule

/* hw/rtl/lio_ctrl.sv */
// Observer controller: sequences item intake, estimate preparation, divisions and commit.
module lio_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lio_pkg::status_type status,
   output lio_pkg::cmd_type    cmd
);

   lio_pkg::state_type state_ff, state_in;
   lio_pkg::op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lio_pkg::ST_IDLE;
         op_ff    <= lio_pkg::OP_R;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      req_tready      = 1'b0;
      cmd.collect     = 1'b0;
      cmd.load        = 1'b0;
      cmd.prep1       = 1'b0;
      cmd.prep2       = 1'b0;
      cmd.prep3       = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_capture = 1'b0;
      cmd.div_op      = op_ff;
      cmd.commit      = 1'b0;
      case (state_ff)
         lio_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (status.run_now) begin
                  cmd.load = 1'b1;
                  state_in = status.go_now ? lio_pkg::ST_PREP1 : lio_pkg::ST_COMMIT;
               end else begin
                  cmd.collect = 1'b1;
               end
            end
         end
         lio_pkg::ST_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = lio_pkg::ST_PREP2;
         end
         lio_pkg::ST_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = lio_pkg::ST_PREP3;
         end
         lio_pkg::ST_PREP3: begin
            cmd.prep3 = 1'b1;
            op_in     = lio_pkg::OP_R;
            state_in  = lio_pkg::ST_DSTART;
         end
         lio_pkg::ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = lio_pkg::ST_DWAIT;
         end
         lio_pkg::ST_DWAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               // averages go last so the estimates see the old ones
               case (op_ff)
                  lio_pkg::OP_R:  op_in = lio_pkg::OP_L;
                  lio_pkg::OP_L:  op_in = lio_pkg::OP_AD;
                  lio_pkg::OP_AD: op_in = lio_pkg::OP_AQ;
                  default:        op_in = lio_pkg::OP_R;
               endcase
               state_in = (op_ff == lio_pkg::OP_AQ) ? lio_pkg::ST_COMMIT : lio_pkg::ST_DSTART;
            end
         end
         lio_pkg::ST_COMMIT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = lio_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lio_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/lr_injection_observer_core.sv */
// Top level of the square-wave injection resistance and inductance observer.
// A collect word is taken without leaving the intake state. A run word whose
// speed condition fails goes straight to commit; one that passes runs three
// multiply stages, then four passes through one shared 32-step restoring
// divider (resistance, inductance, d and q averages), then a commit. The
// commit waits while an earlier result still sits unaccepted in the output
// register. A new word is taken once the previous one has committed, even
// while its result still waits in the output register.
`include "lr_injection_observer_core_assert.svh"
module lr_injection_observer_core #(
   parameter int COUNT_WIDTH = lio_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // vd[15:0] vq[31:16] ehz[63:32] flux[87:64] hfi_active[88] id_request[120:89]
   input  logic [lio_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // r_estimate[31:0] l_estimate[63:32] id_request_out[95:64]
   output logic [lio_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // updated[0]
   output logic [0:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_index,
   input  logic [19:0]                    csr_data
);

   lio_pkg::cmd_type    cmd;
   lio_pkg::status_type status;

   assign csr_ready = 1'b1;

   lio_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lio_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // never overwrite a result that is still waiting
   `LIO_ASSERT_IMP(a_commit_free, clock, reset, cmd.commit, status.out_free)
   // a run word leaves the intake state
   `LIO_ASSERT_NXT(a_run_busy, clock, reset, req_tvalid && req_tready && req_tuser[0], !req_tready)
   // a taken word with no new commit clears the output
   `LIO_ASSERT_NXT(a_rsp_drop, clock, reset, rsp_tvalid && rsp_tready && !cmd.commit, !rsp_tvalid)

endmodule

/* tb/tb.sv */
// Self-checking testbench for the square-wave injection R/L observer core.
module tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct {
      bit                 run;
      logic signed [15:0] vd;
      logic signed [15:0] vq;
      logic signed [31:0] ehz;
      logic [23:0]        flux;
      bit                 hfi;
      logic signed [31:0] id_req;
   } sample_type;

   typedef struct {
      logic [31:0] r_est;
      logic [31:0] l_est;
      logic [31:0] id_out;
      bit          updated;
   } estimate_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [lio_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [lio_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [19:0] csr_data = '0;

   lr_injection_observer_core uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // observer model state
   longint unsigned pwm_hz, inj_amp;
   bit              in_low_phase;
   int unsigned     n_samples;
   longint          vd_lo_sum, vq_lo_sum, vd_hi_sum, vq_hi_sum;
   longint          vd_lo_avg, vq_lo_avg, vd_hi_avg, vq_hi_avg;
   longint          prior_ehz, r_hold, l_hold;

   sample_type   pending_samples[$];
   estimate_type expected_estimates[$];
   int           errors = 0;
   bit           no_idle = 0;
   int           quiet_cycles = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // floor(num * 2^sh / den), capped
   function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                                int sh, longint unsigned cap);
      longint unsigned q, r;
      if (den == 0) return 0;
      q = num / den;
      r = num % den;
      for (int i = 0; i < sh; i++) begin
         if (q > cap) return cap;
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q > cap ? cap : q;
   endfunction

   function automatic longint signed_ratio(bit neg, longint unsigned num,
                                           longint unsigned den, int sh);
      longint unsigned m;
      m = frac_div(num, den, sh, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint mean16(longint sum);
      longint q;
      if (n_samples == 0) return 0;
      q = sum / longint'(n_samples);
      return longint'(signed'(q[15:0]));
   endfunction

   // update the model for one accepted word; queue a result for run words
   function automatic void predict_estimate(sample_type s);
      longint vd, vq, e, id, dd, dq, de, n;
      longint unsigned p, t2, den;
      bit go;
      estimate_type x;
      vd = s.vd;
      vq = s.vq;
      e = s.ehz;
      id = s.id_req;
      go = !s.hfi && magnitude(e) * 200 > (pwm_hz << 16);
      if (!s.run) begin
         if (n_samples < 65535) n_samples++;
         if (go) begin
            if (in_low_phase) begin
               vd_lo_sum = clamp32(vd_lo_sum + vd);
               vq_lo_sum = clamp32(vq_lo_sum + vq);
            end else begin
               vd_hi_sum = clamp32(vd_hi_sum + vd);
               vq_hi_sum = clamp32(vq_hi_sum + vq);
            end
         end
         return;
      end
      if (go) begin
         dd = vd_hi_avg - vd_lo_avg;
         dq = vq_hi_avg - vq_lo_avg;
         de = e - prior_ehz;
         p = magnitude(de) * s.flux;
         t2 = (((p >> 16) * lio_pkg::K628) + (((p & 64'hFFFF) * lio_pkg::K628) >> 16)) >> 16;
         n = dq * 65536 - (de < 0 ? -longint'(t2) : longint'(t2));
         den = ((inj_amp * lio_pkg::K628) >> 8) * magnitude(e);
         if (inj_amp == 0) begin
            r_hold = 0;
            l_hold = 0;
         end else begin
            r_hold = signed_ratio(dd < 0, magnitude(dd), inj_amp, 23);
            l_hold = signed_ratio((n < 0) != (e < 0), magnitude(n), den, 47);
         end
         if (in_low_phase) begin
            in_low_phase = 0;
            vd_lo_avg = mean16(vd_lo_sum);
            vq_lo_avg = mean16(vq_lo_sum);
            id = clamp32(id + longint'(inj_amp));
            vd_lo_sum = 0;
            vq_lo_sum = 0;
         end else begin
            in_low_phase = 1;
            vd_hi_avg = mean16(vd_hi_sum);
            vq_hi_avg = mean16(vq_hi_sum);
            id = clamp32(id - longint'(inj_amp));
            vd_hi_sum = 0;
            vq_hi_sum = 0;
         end
         prior_ehz = e;
         n_samples = 0;
      end
      x.r_est = r_hold[31:0];
      x.l_est = l_hold[31:0];
      x.id_out = id[31:0];
      x.updated = go;
      expected_estimates.push_back(x);
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (no_idle || k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sender
   sample_type cur;
   int         req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_estimate(cur);
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 0;
            end else if (pending_samples.size() > 0) begin
               cur = pending_samples.pop_front();
               req_tdata <= {7'd0, cur.id_req, cur.hfi, cur.flux, cur.ehz, cur.vq, cur.vd};
               req_tuser <= cur.run;
               req_tvalid <= 1;
               req_gap = pick_gap();
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // receiver and watchdog
   int rsp_gap = 0;
   always @(posedge clock) begin
      estimate_type x;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_estimates.size() == 0) begin
               $error("result word with no estimate pending");
               errors++;
            end else begin
               x = expected_estimates.pop_front();
               if (rsp_tdata[31:0] !== x.r_est) begin
                  $error("r_estimate: expected %h, got %h", x.r_est, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== x.l_est) begin
                  $error("l_estimate: expected %h, got %h", x.l_est, rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tdata[95:64] !== x.id_out) begin
                  $error("id_request_out: expected %h, got %h", x.id_out, rsp_tdata[95:64]);
                  errors++;
               end
               if (rsp_tuser[0] !== x.updated) begin
                  $error("updated: expected %b, got %b", x.updated, rsp_tuser[0]);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            rsp_gap = pick_gap();
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(lio_pkg::csr_index_type idx, logic [19:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == lio_pkg::CSR_PWM) pwm_hz = value[17:0];
      else inj_amp = value;
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_tvalid || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic sample_type make_sample(bit run, int vd, int vq, int ehz, int flux,
                                              bit hfi, int id_req);
      sample_type s;
      s.run = run;
      s.vd = vd;
      s.vq = vq;
      s.ehz = ehz;
      s.flux = flux;
      s.hfi = hfi;
      s.id_req = id_req;
      return s;
   endfunction

   function automatic int fast_speed();
      longint unsigned lo, mag;
      lo = (pwm_hz * 65536) / 200 + 1;
      if ($urandom_range(0, 3) == 0) mag = lo + $urandom_range(0, 4096);
      else mag = lo + ($urandom() % (64'h8000_0000 - lo));
      return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
   endfunction

   function automatic int rand_volt();
      return $urandom_range(0, 4) == 0 ? int'($urandom()) : $urandom_range(0, 2000) - 1000;
   endfunction

   // mostly collect bursts closed by a run word, with some slow or HFI noise
   task automatic queue_bursts(int total);
      int made, k, e;
      bit noise;
      made = 0;
      while (made < total) begin
         k = $urandom_range(0, 10);
         e = fast_speed();
         for (int i = 0; i <= k; i++) begin
            noise = $urandom_range(0, 99) < 12;
            pending_samples.push_back(make_sample(i == k, rand_volt(), rand_volt(),
               noise ? int'($urandom()) : e + int'($urandom_range(0, 255)) - 128,
               $urandom(), noise && $urandom_range(0, 1), $urandom()));
            made++;
         end
      end
   endtask

   initial begin
      pwm_hz = lio_pkg::PWM_RESET;
      inj_amp = lio_pkg::INJ_RESET;
      in_low_phase = 1;
      n_samples = 0;
      vd_lo_sum = 0; vq_lo_sum = 0; vd_hi_sum = 0; vq_hi_sum = 0;
      vd_lo_avg = 0; vq_lo_avg = 0; vd_hi_avg = 0; vq_hi_avg = 0;
      prior_ehz = 0; r_hold = 0; l_hold = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: run on empty count, extremes, slow speed, HFI, id saturation
      pending_samples.push_back(make_sample(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 32767, -32768, 32'h7FFF_FFFF, 24'hFFFFFF, 0, 0));
      pending_samples.push_back(make_sample(0, 32767, -32768, 32'h7FFF_FFFF, 0, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 32'h8000_0000, 24'hFFFFFF, 0,
                                            32'h7FFF_FFFF));
      pending_samples.push_back(make_sample(0, -32768, 32767, 32'h8000_0000, 0, 0, 0));
      pending_samples.push_back(make_sample(0, -32768, 32767, -7000000, 0, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, -7000000, 24'hFFFFFF, 0,
                                            32'h8000_0000));
      pending_samples.push_back(make_sample(0, 1000, 500, 0, 5, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 0, 5, 0, 42));
      pending_samples.push_back(make_sample(0, 1000, 500, 32'h7FFF_FFFF, 5, 1, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 32'h7FFF_FFFF, 5, 1, 17));
      pending_samples.push_back(make_sample(0, 256, -256, 6553600, 100, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 6553600, 100, 0, 32'h7FFF_FFFF));
      pending_samples.push_back(make_sample(0, 256, -256, 6553601, 100, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 6553601, 100, 0, 32'h8000_0000));
      pending_samples.push_back(make_sample(0, -1, 1, -6553601, 24'hFFFFFF, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, -6553601, 24'hFFFFFF, 0, -1));
      drain();

      write_csr(lio_pkg::CSR_PWM, 1000);
      write_csr(lio_pkg::CSR_INJ, 20'hFFFFF);
      queue_bursts(200);
      drain();

      write_csr(lio_pkg::CSR_PWM, 200000);
      write_csr(lio_pkg::CSR_INJ, 1);
      queue_bursts(200);
      drain();

      write_csr(lio_pkg::CSR_INJ, 0);
      write_csr(lio_pkg::CSR_PWM, 20000);
      queue_bursts(60);
      drain();

      // back-to-back words in two long phases with extreme voltages
      write_csr(lio_pkg::CSR_PWM, 1000);
      write_csr(lio_pkg::CSR_INJ, 65536);
      no_idle = 1;
      for (int i = 0; i < 30; i++)
         pending_samples.push_back(make_sample(0, 32767, -32768, 32'h7FFF_FFFF, 0, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
      for (int i = 0; i < 30; i++)
         pending_samples.push_back(make_sample(0, -32768, 32767, 32'h7FFF_FFFF, 0, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
      drain();
      no_idle = 0;

      write_csr(lio_pkg::CSR_PWM, 20'($urandom_range(1000, 200000)));
      write_csr(lio_pkg::CSR_INJ, 20'($urandom_range(1, 20'hFFFFF)));
      queue_bursts(200);
      drain();

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
